FILE: rtl/core/ssfd_pkg.sv
// Shared types, constants and helpers for the sine shaper with feedback delay.
// Used by every module of the block but the RAM; depends on nothing else.
package ssfd_pkg;

    localparam int DelayDepth = 4096;
    localparam int AddrW      = $clog2(DelayDepth);
    localparam int LenW       = 13;
    localparam int StoreW     = 18;

    localparam logic [15:0] QuarterWave = 16'd16384;
    localparam logic [15:0] HalfWave    = 16'd32768;

    localparam logic [15:0]        DriveReset  = 16'd24576;
    localparam logic [14:0]        LimitReset  = 15'd8000;
    localparam logic [LenW-1:0]    LengthReset = LenW'(DelayDepth);

    typedef logic signed [31:0] t_op;
    typedef logic signed [63:0] t_prod;

    localparam t_op HornerC5 = 32'sd172271;
    localparam t_op HornerC4 = -32'sd5026994;
    localparam t_op HornerC3 = 32'sd85569306;
    localparam t_op HornerC2 = -32'sd693598668;
    localparam t_op HornerC1 = 32'sd1686629713;

    typedef struct packed {
        logic signed [16:0] sample_in;
        logic               block_end;
    } t_in;

    typedef struct packed {
        logic signed [18:0] sample_out;
        logic               block_last;
    } t_out;

    typedef struct packed {
        logic [15:0]        drive;
        logic [14:0]        limit;
        logic signed [15:0] wet_gain;
        logic signed [15:0] feedback_gain;
        logic [LenW-1:0]    len_eff;
    } t_cfg;

    typedef enum logic [2:0] {
        CFG_DRIVE,
        CFG_LIMIT,
        CFG_WET_GAIN,
        CFG_FEEDBACK_GAIN,
        CFG_DELAY_LENGTH
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SQ, S_T2,
        S_H1, S_A1, S_H2, S_A2, S_H3, S_A3, S_H4, S_A4,
        S_H5, S_A5, S_DRV, S_A6, S_WET, S_A7, S_FB, S_WR
    } t_state;

    // Arithmetic right shift that rounds toward zero.
    function automatic t_prod trunc_shr(input t_prod p, input int unsigned sh);
        t_prod bias;
        bias = p[63] ? ((t_prod'(1) <<< sh) - t_prod'(1)) : t_prod'(0);
        return (p + bias) >>> sh;
    endfunction

endpackage

FILE: rtl/core/sine_shaper_feedback_delay.sv
// Sine waveshaper with a feedback delay line: each sample is shaped by a sine
// term of the drive setting, clamped to the limit, and summed with the delayed
// value; wet and feedback gains write the next delay entry. After reset the
// block zeroes every delay store entry and takes no beat during that time.
// Each sample is finished before the next is accepted, since one shared
// multiplier forms nine products in series (five for the sine polynomial,
// one for the drive, two for the gains and one square), each followed by a
// rounding step. A finished beat waits in the output register, so a new
// sample can be taken while the previous result is stalled.
// Configuration writes land at once and should be made only while idle.
module sine_shaper_feedback_delay (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ssfd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ssfd_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import ssfd_pkg::*;

    logic [15:0]        r_drive;
    logic [14:0]        r_limit;
    logic signed [15:0] r_wet_gain;
    logic signed [15:0] r_feedback_gain;
    logic [LenW-1:0]    r_delay_length;
    logic               r_out_valid;
    t_out               r_out_data;

    t_cfg cfg;
    logic res_valid;
    logic res_ready;
    t_out res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive         <= DriveReset;
            r_limit         <= LimitReset;
            r_wet_gain      <= '0;
            r_feedback_gain <= '0;
            r_delay_length  <= LengthReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DRIVE:         r_drive         <= i_cfg_data;
                CFG_LIMIT:         r_limit         <= i_cfg_data[14:0];
                CFG_WET_GAIN:      r_wet_gain      <= $signed(i_cfg_data);
                CFG_FEEDBACK_GAIN: r_feedback_gain <= $signed(i_cfg_data);
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data[LenW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.drive         = r_drive;
        cfg.limit         = r_limit;
        cfg.wet_gain      = r_wet_gain;
        cfg.feedback_gain = r_feedback_gain;
        priority if (r_delay_length == '0) begin
            cfg.len_eff = LenW'(1);
        end else if (r_delay_length > LenW'(DelayDepth)) begin
            cfg.len_eff = LenW'(DelayDepth);
        end else begin
            cfg.len_eff = r_delay_length;
        end
    end

    ssfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/ssfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; holds the delay store.
module ssfd_ram #(
    parameter int Depth = 4096,
    parameter int Width = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ssfd_mul.sv
// Shared 32 by 32 signed multiplier with a registered product.
// Depends on ssfd_pkg for the operand and product types.
module ssfd_mul (
    input  logic          i_clk,
    input  ssfd_pkg::t_op i_a,
    input  ssfd_pkg::t_op i_b,
    output ssfd_pkg::t_prod o_p
);
    import ssfd_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_p = r_prod;

endmodule

FILE: rtl/core/ssfd_core.sv
// Sequencer and datapath: sine polynomial, shaping, clamping and delay store update.
// Depends on ssfd_pkg, ssfd_mul and ssfd_ram.
module ssfd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssfd_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ssfd_pkg::t_in  i_in_data,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output ssfd_pkg::t_out o_res_data
);
    import ssfd_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [AddrW-1:0] r_clr_addr;
    logic [AddrW-1:0] r_rptr;
    logic [AddrW-1:0] r_wr;
    logic signed [15:0] r_x;
    logic               r_last;
    logic [14:0]        r_a;
    logic signed [17:0] r_d;
    logic [30:0]        r_t2;
    t_op                r_y;
    logic signed [15:0] r_sine;
    logic signed [15:0] r_shaped;
    logic signed [16:0] r_w;

    t_op   mul_a;
    t_op   mul_b;
    t_prod prod;

    logic              ram_we;
    logic [AddrW-1:0]  ram_waddr;
    logic [StoreW-1:0] ram_wdata;
    logic [StoreW-1:0] ram_rdata;
    logic              in_acc;

    logic signed [16:0] x_in;
    logic signed [15:0] x_sat;
    logic [15:0]        x_abs;
    logic [15:0]        a_fold;
    logic [AddrW:0]     rp_inc;
    logic [AddrW-1:0]   rp_eff;
    logic [AddrW-1:0]   rp_next;
    logic [LenW-1:0]    len_m1;
    logic [AddrW-1:0]   wr_addr;

    t_prod              div30;
    t_prod              div14;
    t_prod              div15;
    t_op                horner_c;
    t_op                y5;
    logic [32:0]        y5_rnd;
    logic [17:0]        q18;
    logic [14:0]        q;
    logic signed [15:0] sine;
    logic signed [17:0] x2;
    logic signed [17:0] lim_s;
    logic signed [17:0] x2_clamped;
    logic signed [18:0] w_sum;
    logic signed [17:0] w_sat;

    ssfd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ssfd_ram #(
        .Depth (DelayDepth),
        .Width (StoreW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (rp_eff),
        .o_rdata (ram_rdata)
    );

    // Input conditioning and pointer arithmetic for the beat being accepted.
    always_comb begin
        x_in = i_in_data.sample_in;
        if (x_in > 17'sd32767) begin
            x_sat = 16'sd32767;
        end else if (x_in < -17'sd32767) begin
            x_sat = -16'sd32767;
        end else begin
            x_sat = x_in[15:0];
        end
        x_abs  = x_sat[15] ? 16'(-x_sat) : 16'(x_sat);
        a_fold = (x_abs > QuarterWave) ? (HalfWave - x_abs) : x_abs;

        rp_eff  = ({1'b0, r_rptr} >= i_cfg.len_eff) ? '0 : r_rptr;
        rp_inc  = {1'b0, rp_eff} + 1'b1;
        rp_next = (rp_inc >= i_cfg.len_eff) ? '0 : rp_inc[AddrW-1:0];
        len_m1  = i_cfg.len_eff - 1'b1;
        wr_addr = (rp_eff == '0) ? len_m1[AddrW-1:0] : (rp_eff - 1'b1);
    end

    // Post-processing of the registered product.
    always_comb begin
        div30 = trunc_shr(prod, 30);
        div14 = trunc_shr(prod, 14);
        div15 = trunc_shr(prod, 15);

        unique case (r_state)
            S_A1:    horner_c = HornerC4;
            S_A2:    horner_c = HornerC3;
            S_A3:    horner_c = HornerC2;
            S_A4:    horner_c = HornerC1;
            default: horner_c = '0;
        endcase

        y5     = div14[31:0];
        y5_rnd = (y5 < 0) ? 33'd16384 : ({1'b0, y5} + 33'd16384);
        q18    = y5_rnd[32:15];
        q      = (q18 > 18'd32767) ? 15'd32767 : q18[14:0];
        sine   = r_x[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});

        lim_s = $signed({3'b000, i_cfg.limit});
        x2    = 18'(r_x) + div15[17:0];
        if (x2 > lim_s) begin
            x2_clamped = lim_s;
        end else if (x2 < -lim_s) begin
            x2_clamped = -lim_s;
        end else begin
            x2_clamped = x2;
        end

        w_sum = 19'(r_w) + $signed(div15[18:0]);
        if (w_sum > 19'sd131071) begin
            w_sat = 18'sd131071;
        end else if (w_sum < -19'sd131072) begin
            w_sat = -18'sd131072;
        end else begin
            w_sat = w_sum[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        in_acc      = 1'b0;
        o_res_valid = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr;
        ram_wdata   = w_sat;
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == AddrW'(DelayDepth - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    in_acc  = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                mul_a   = {17'd0, r_a};
                mul_b   = {17'd0, r_a};
                n_state = S_T2;
            end
            S_T2: n_state = S_H1;
            S_H1: begin
                mul_a   = HornerC5;
                mul_b   = {1'b0, r_t2};
                n_state = S_A1;
            end
            S_A1: n_state = S_H2;
            S_H2: begin
                mul_a   = r_y;
                mul_b   = {1'b0, r_t2};
                n_state = S_A2;
            end
            S_A2: n_state = S_H3;
            S_H3: begin
                mul_a   = r_y;
                mul_b   = {1'b0, r_t2};
                n_state = S_A3;
            end
            S_A3: n_state = S_H4;
            S_H4: begin
                mul_a   = r_y;
                mul_b   = {1'b0, r_t2};
                n_state = S_A4;
            end
            S_A4: n_state = S_H5;
            S_H5: begin
                mul_a   = r_y;
                mul_b   = {17'd0, r_a};
                n_state = S_A5;
            end
            S_A5: n_state = S_DRV;
            S_DRV: begin
                mul_a   = {16'd0, i_cfg.drive};
                mul_b   = 32'(r_sine);
                n_state = S_A6;
            end
            S_A6: n_state = S_WET;
            S_WET: begin
                mul_a   = 32'(i_cfg.wet_gain);
                mul_b   = 32'(r_shaped);
                n_state = S_A7;
            end
            S_A7: n_state = S_FB;
            S_FB: begin
                mul_a   = 32'(i_cfg.feedback_gain);
                mul_b   = 32'(r_d);
                n_state = S_WR;
            end
            S_WR: begin
                // The feedback product is kept in the multiplier while the result waits.
                mul_a = 32'(i_cfg.feedback_gain);
                mul_b = 32'(r_d);
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    ram_we      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rptr     <= '0;
        end else begin
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (in_acc) begin
                r_rptr <= rp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= x_sat;
            r_last <= i_in_data.block_end;
            r_a    <= a_fold[14:0];
            r_wr   <= wr_addr;
        end
        unique case (r_state)
            S_SQ:  r_d <= $signed(ram_rdata);
            S_T2:  r_t2 <= {prod[28:0], 2'b00};
            S_A1, S_A2, S_A3, S_A4: r_y <= horner_c + div30[31:0];
            S_A5:  r_sine <= sine;
            S_A6:  r_shaped <= x2_clamped[15:0];
            S_A7:  r_w <= div15[16:0];
            default: begin
            end
        endcase
    end

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_res_data.sample_out  = 19'(r_d) + 19'(r_shaped);
    assign o_res_data.block_last  = r_last;

endmodule

FILE: test/sine_shaper_feedback_delay_checker.sv
// Checker for the sine shaper with feedback delay: watches the input, output and register ports,
// predicts each output beat from its own model of the shaper and delay store, and counts failures.
// Depends on ssfd_pkg for the beat and register index types.
module sine_shaper_feedback_delay_checker
    import ssfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam longint Q30       = 64'sd1073741824;
    localparam longint StoreHigh = 64'sd131071;
    localparam longint StoreLow  = -64'sd131072;

    logic [15:0]        drive;
    logic [14:0]        limit;
    logic signed [15:0] wet_gain;
    logic signed [15:0] feedback_gain;
    logic [LenW-1:0]    delay_length;

    int   delay_line [DelayDepth];
    int   tap;
    t_out expected_beats [$];

    function automatic longint sine_q15(input longint x);
        longint a, t, t2, y, q;
        a = (x < 0) ? -x : x;
        if (a > 16384) a = 32768 - a;
        t  = (a * Q30) / 16384;
        t2 = (t * t) / Q30;
        y  = 64'sd172271;
        y  = -64'sd5026994 + (y * t2) / Q30;
        y  = 64'sd85569306 + (y * t2) / Q30;
        y  = -64'sd693598668 + (y * t2) / Q30;
        y  = 64'sd1686629713 + (y * t2) / Q30;
        y  = (y * t) / Q30;
        if (y < 0) y = 0;
        q = (y + 16384) >>> 15;
        if (q > 32767) q = 32767;
        return (x < 0) ? -q : q;
    endfunction

    function automatic t_out shape_and_delay(input t_in beat);
        longint x, d, w, lim, span;
        int     wr;
        t_out   res;
        x    = longint'(beat.sample_in);
        span = longint'(delay_length);
        if (span == 0) span = 1;
        if (span > DelayDepth) span = DelayDepth;
        if (tap >= span) tap = 0;

        if (x > 32767) x = 32767;
        if (x < -32767) x = -32767;
        x   = x + (longint'(drive) * sine_q15(x)) / 32768;
        lim = longint'(limit);
        if (x > lim) x = lim;
        if (x < -lim) x = -lim;

        d = longint'(delay_line[tap]);
        w = (longint'(wet_gain) * x) / 32768 + (longint'(feedback_gain) * d) / 32768;
        if (w > StoreHigh) w = StoreHigh;
        if (w < StoreLow) w = StoreLow;
        wr = (tap == 0) ? int'(span) - 1 : tap - 1;
        delay_line[wr] = int'(w);

        tap++;
        if (tap >= span) tap = 0;

        res.sample_out = 19'(d + x);
        res.block_last = beat.block_end;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            drive         = DriveReset;
            limit         = LimitReset;
            wet_gain      = '0;
            feedback_gain = '0;
            delay_length  = LengthReset;
            tap           = 0;
            foreach (delay_line[i]) delay_line[i] = 0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DRIVE:         drive = i_cfg_data;
                    CFG_LIMIT:         limit = i_cfg_data[14:0];
                    CFG_WET_GAIN:      wet_gain = i_cfg_data;
                    CFG_FEEDBACK_GAIN: feedback_gain = i_cfg_data;
                    CFG_DELAY_LENGTH:  delay_length = i_cfg_data[LenW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected output beat: sample_out %0d block_last %0b",
                                 i_out_data.sample_out, i_out_data.block_last);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data.sample_out !== want.sample_out ||
                        i_out_data.block_last !== want.block_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: sample_out exp %0d got %0d, block_last exp %0b got %0b",
                                     want.sample_out, i_out_data.sample_out,
                                     want.block_last, i_out_data.block_last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_beats.push_back(shape_and_delay(i_in_data));
        end
        o_pending = expected_beats.size();
    end

endmodule

FILE: test/sine_shaper_feedback_delay_tb.sv
// Top-level testbench for sine_shaper_feedback_delay: drives directed and random samples through
// several register settings with random idling and a long output hold-off, and gives the verdict.
// Depends on ssfd_pkg, the block itself and sine_shaper_feedback_delay_checker.
module sine_shaper_feedback_delay_tb;
    import ssfd_pkg::*;

    localparam int QuietLimit = 20000;
    localparam int HoldCycles = 300;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    int errors;
    int pending;
    int quiet;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    int corner_samples [10] = '{0, 65535, -65536, 32767, -32767, -32768, 1, -1, 16384, -16384};

    sine_shaper_feedback_delay u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    sine_shaper_feedback_delay_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QuietLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The output side stalls at random, or holds off for a long stretch when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_stall <= idle_on && ($urandom_range(0, 99) < 9);
            end
        end
    end

    task automatic offer_sample(input int v, input logic last);
        t_in beat;
        beat.sample_in = 17'(v);
        beat.block_end = last;
        while (idle_on && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0 || in_stall) @(negedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] drv, lim, wet, fb, len);
        put_reg(CFG_DRIVE, drv);
        put_reg(CFG_LIMIT, lim);
        put_reg(CFG_WET_GAIN, wet);
        put_reg(CFG_FEEDBACK_GAIN, fb);
        put_reg(CFG_DELAY_LENGTH, len);
        cfg_we <= 1'b0;
    endtask

    function automatic int random_sample();
        case ($urandom_range(0, 9))
            0:       return corner_samples[$urandom_range(0, 9)];
            1, 2, 3: return int'($urandom_range(0, 131071)) - 65536;
            default: return int'($urandom_range(0, 65534)) - 32767;
        endcase
    endfunction

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] drv, lim, len;
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: full-length delay, so outputs are the shaped samples alone.
        for (int i = 0; i < 10; i++) offer_sample(corner_samples[i], 1'(i % 2));

        // A zero delay length acts as one slot, read before write; gains at their extremes.
        drain();
        program_regs(16'd65535, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0);
        offer_sample(32767, 1'b0);
        offer_sample(-32767, 1'b1);
        offer_sample(20000, 1'b0);
        offer_sample(-5, 1'b1);

        // A zero limit forces the shaped sample to zero.
        drain();
        program_regs(16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd1);
        offer_sample(30000, 1'b1);
        offer_sample(-30000, 1'b0);
        offer_sample(100, 1'b1);

        // A length beyond the store depth is taken as the full depth.
        drain();
        program_regs(16'd49152, 16'd18000, 16'h8000, 16'h8000, 16'd8191);
        offer_sample(-65536, 1'b0);
        offer_sample(65535, 1'b1);
        offer_sample(12345, 1'b0);

        // Shortened length with the read pointer beyond it, so it wraps to slot zero.
        drain();
        program_regs(16'd24576, 16'd8000, 16'd16384, 16'd16384, 16'd2);
        offer_sample(8000, 1'b0);
        offer_sample(-12000, 1'b0);
        offer_sample(500, 1'b1);
        offer_sample(-32768, 1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            case ($urandom_range(0, 3))
                0:       drv = 16'd0;
                1:       drv = 16'd49152;
                2:       drv = 16'd65535;
                default: drv = 16'($urandom_range(0, 49152));
            endcase
            case ($urandom_range(0, 5))
                0:       lim = 16'd0;
                1:       lim = 16'h7FFF;
                2:       lim = 16'd8000;
                default: lim = 16'($urandom_range(8000, 18000));
            endcase
            case ($urandom_range(0, 9))
                0:       len = 16'd0;
                1:       len = 16'd4096;
                2:       len = 16'd8191;
                3:       len = 16'($urandom_range(0, 8191));
                default: len = 16'($urandom_range(1, 40));
            endcase
            program_regs(drv, lim, random_gain(), random_gain(), len);
            idle_on = !(ph inside {4, 5});
            for (int n = 0; n < 113; n++) begin
                if (ph == 2 && n == 20) hold_req = 1'b1;
                offer_sample(random_sample(), 1'($urandom_range(0, 7) == 0));
            end
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
